FILE: design/jacc_pkg.sv
// Shared types, constants and codes for the joystick axis calibrate and classify block.
// No dependencies; imported by every module of the block.
package jacc_pkg;

   localparam int SAMPLE_W        = 10;
   localparam int POS_W           = 11;
   localparam int DIR_W           = 2;
   localparam int DZ_W            = 9;
   localparam int DEFAULT_SAMPLES = 5;

   localparam int AXIS_MAX  = 1023;
   localparam int AXIS_MID  = 512;
   localparam int POS_LIMIT = 512;
   localparam int POS_SHIFT = $clog2(POS_LIMIT);

   localparam int DIV_W      = 20;
   localparam int DIV_STEP   = 2;
   localparam int DIV_CYCLES = DIV_W / DIV_STEP;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

   localparam int REQ_DATA_W   = 24;
   localparam int RSP_FIELDS_W = 2 * POS_W + 2 * DIR_W + 2;
   localparam int RSP_DATA_W   = 32;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;

   localparam logic [DZ_W-1:0]       DEAD_ZONE_RESET = DZ_W'(100);
   localparam logic [CSR_ADDR_W-1:0] REG_DEAD_ZONE   = CSR_ADDR_W'(0);

   typedef enum logic [DIR_W-1:0] {
      DIR_CENTRE = 2'd0,
      DIR_NEG    = 2'd1,
      DIR_POS    = 2'd2
   } dir_type;

   typedef enum logic [1:0] {
      OP_ACCUM     = 2'd0,
      OP_CALIBRATE = 2'd1,
      OP_MAP       = 2'd2
   } lane_op_type;

   typedef struct packed {
      logic        start;
      lane_op_type op;
      logic        calibrated;
   } lane_cmd_type;

   typedef struct packed {
      logic                    done;
      logic signed [POS_W-1:0] position;
      dir_type                 direction;
   } lane_rsp_type;

endpackage

FILE: design/jacc_div.sv
// Iterative restoring divider, two quotient bits per cycle.
// Depends on jacc_pkg.
module jacc_div
   import jacc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIV_W-1:0]    dividend,
   input  logic [SAMPLE_W-1:0] divisor,
   output logic                done,
   output logic [DIV_W-1:0]    quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [SAMPLE_W-1:0]  dsr_ff, dsr_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;

   always_comb begin
      logic [SAMPLE_W:0]   trial;
      logic [SAMPLE_W-1:0] r;
      logic [DIV_W-1:0]    q;
      r     = rem_ff;
      q     = quo_ff;
      trial = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {r, q[DIV_W-1]};
         q     = {q[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            trial = trial - {1'b0, dsr_ff};
            q[0]  = 1'b1;
         end
         r = trial[SAMPLE_W-1:0];
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = r;
         quo_in = q;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: design/jacc_lane.sv
// One axis lane: calibration sum, centre, position mapping and dead-zone direction.
// Depends on jacc_pkg and jacc_div.
module jacc_lane
   import jacc_pkg::*;
#(
   parameter int SAMPLES = DEFAULT_SAMPLES
)
(
   input  logic                clock,
   input  logic                reset,
   input  lane_cmd_type        cmd,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [DZ_W-1:0]     dead_zone,
   output lane_rsp_type        rsp
);

   localparam int ACC_W = $clog2(SAMPLES * AXIS_MAX + 1);

   typedef enum logic [1:0] {
      L_IDLE = 2'b01,
      L_DIV  = 2'b10
   } lane_state_type;

   function automatic dir_type classify(input logic signed [POS_W-1:0] p,
                                        input logic [DZ_W-1:0] dz);
      logic signed [POS_W-1:0] dzs;
      dzs = $signed(POS_W'(dz));
      if (p < -dzs) return DIR_NEG;
      if (p > dzs) return DIR_POS;
      return DIR_CENTRE;
   endfunction

   lane_state_type          state_ff, state_in;
   lane_op_type             op_ff, op_in;
   logic                    lower_ff, lower_in;
   logic                    done_ff, done_in;
   logic [ACC_W-1:0]        accum_ff, accum_in;
   logic [SAMPLE_W-1:0]     centre_ff, centre_in;
   logic signed [POS_W-1:0] pos_ff, pos_in;
   dir_type                 dir_ff, dir_in;

   logic                    div_start;
   logic [DIV_W-1:0]        div_dividend;
   logic [SAMPLE_W-1:0]     div_divisor;
   logic                    div_done;
   logic [DIV_W-1:0]        div_q;

   logic [ACC_W-1:0]        sum;
   logic [SAMPLE_W-1:0]     diff;
   logic [SAMPLE_W-1:0]     span;
   logic [SAMPLE_W-1:0]     q_lim;
   logic signed [POS_W-1:0] pos_mag;
   logic signed [POS_W-1:0] pos_div;
   logic signed [POS_W-1:0] pos_raw;

   jacc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   assign sum  = accum_ff + ACC_W'(sample);
   assign diff = sample - centre_ff;
   assign span = SAMPLE_W'(AXIS_MAX) - centre_ff;

   assign q_lim   = (div_q > DIV_W'(POS_LIMIT)) ? SAMPLE_W'(POS_LIMIT) : div_q[SAMPLE_W-1:0];
   assign pos_mag = $signed({1'b0, q_lim});
   assign pos_div = lower_ff ? pos_mag - $signed(POS_W'(POS_LIMIT)) : pos_mag;
   assign pos_raw = $signed({1'b0, sample}) - $signed(POS_W'(AXIS_MID));

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      lower_in     = lower_ff;
      done_in      = 1'b0;
      accum_in     = accum_ff;
      centre_in    = centre_ff;
      pos_in       = pos_ff;
      dir_in       = dir_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      unique case (state_ff)
         L_IDLE: begin
            if (cmd.start) begin
               op_in = cmd.op;
               unique case (cmd.op)
                  OP_ACCUM: begin
                     accum_in = sum;
                     pos_in   = '0;
                     dir_in   = DIR_CENTRE;
                     done_in  = 1'b1;
                  end
                  OP_CALIBRATE: begin
                     accum_in     = '0;
                     div_start    = 1'b1;
                     div_dividend = DIV_W'(sum);
                     div_divisor  = SAMPLE_W'(SAMPLES);
                     state_in     = L_DIV;
                  end
                  OP_MAP: begin
                     if (!cmd.calibrated) begin
                        pos_in  = pos_raw;
                        dir_in  = classify(pos_raw, dead_zone);
                        done_in = 1'b1;
                     end else if (sample > centre_ff) begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'({diff, {POS_SHIFT{1'b0}}});
                        div_divisor  = span;
                        lower_in     = 1'b0;
                        state_in     = L_DIV;
                     end else if (centre_ff == '0) begin
                        // empty lower range
                        pos_in  = '0;
                        dir_in  = classify('0, dead_zone);
                        done_in = 1'b1;
                     end else begin
                        div_start    = 1'b1;
                        div_dividend = DIV_W'({sample, {POS_SHIFT{1'b0}}});
                        div_divisor  = centre_ff;
                        lower_in     = 1'b1;
                        state_in     = L_DIV;
                     end
                  end
                  default: begin
                     done_in = 1'b1;
                  end
               endcase
            end
         end
         L_DIV: begin
            if (div_done) begin
               done_in  = 1'b1;
               state_in = L_IDLE;
               if (op_ff == OP_CALIBRATE) begin
                  centre_in = div_q[SAMPLE_W-1:0];
                  pos_in    = '0;
                  dir_in    = DIR_CENTRE;
               end else begin
                  pos_in = pos_div;
                  dir_in = classify(pos_div, dead_zone);
               end
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= L_IDLE;
         done_ff   <= 1'b0;
         accum_ff  <= '0;
         centre_ff <= SAMPLE_W'(AXIS_MID);
      end else begin
         state_ff  <= state_in;
         done_ff   <= done_in;
         accum_ff  <= accum_in;
         centre_ff <= centre_in;
      end
      op_ff    <= op_in;
      lower_ff <= lower_in;
      pos_ff   <= pos_in;
      dir_ff   <= dir_in;
   end

   assign rsp = '{done: done_ff, position: pos_ff, direction: dir_ff};

endmodule

FILE: design/joystick_axis_calibrate_and_classify.sv
// Joystick axis calibrate and classify: one transaction in, one transaction out. An item
// with tuser high is a calibration sample; after SAMPLES of them both axis centres are
// replaced by the truncated mean. Other items give a signed position in -512..512 per axis
// and a direction beyond the dead zone held in the CSR at byte address 0. One item is in
// work at a time. Calibration sums, uncalibrated readings and calibrated readings in the
// zero-width lower range are answered by the lanes without the divider; other calibrated
// readings and the sample that closes a calibration run pass through the two-bits-per-cycle
// divider in each axis lane (load, ten iterations, lane register, merge).
// The next item is accepted the cycle after its predecessor's result is registered.
// Depends on jacc_pkg, jacc_lane and jacc_div.
module joystick_axis_calibrate_and_classify
   import jacc_pkg::*;
#(
   parameter int SAMPLES = DEFAULT_SAMPLES
)
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // x_sample[9:0], y_sample[19:10], zero pad
   input  logic                  req_tuser,   // func

   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // x_position[10:0], y_position[21:11],
                                              // x_heading[23:22], y_heading[25:24],
                                              // calibration_done[26], is_calibrated[27]

   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int CNT_W        = $clog2(SAMPLES + 1);
   localparam int CAL_DONE_BIT = 2 * POS_W + 2 * DIR_W;
   localparam int IS_CAL_BIT   = CAL_DONE_BIT + 1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_BUSY = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  cal_flag_ff, cal_flag_in;
   logic                  cal_done_ff, cal_done_in;
   logic [1:0]            seen_ff, seen_in;
   logic [DZ_W-1:0]       dz_ff, dz_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   logic                  csr_write;
   logic [CNT_W-1:0]      count_next;
   logic                  finish;
   logic [1:0]            seen_now;
   logic                  out_free;
   logic                  load;
   lane_cmd_type          lane_cmd;
   lane_rsp_type          x_rsp, y_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;

   assign count_next = count_ff + CNT_W'(1);
   assign finish     = req_tuser && (count_next >= CNT_W'(SAMPLES));

   always_comb begin
      lane_cmd.start      = req_accept;
      lane_cmd.calibrated = cal_flag_ff;
      if (!req_tuser) begin
         lane_cmd.op = OP_MAP;
      end else if (finish) begin
         lane_cmd.op = OP_CALIBRATE;
      end else begin
         lane_cmd.op = OP_ACCUM;
      end
   end

   jacc_lane #(.SAMPLES(SAMPLES)) u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lane_cmd),
      .sample    (req_tdata[SAMPLE_W-1:0]),
      .dead_zone (dz_ff),
      .rsp       (x_rsp)
   );

   jacc_lane #(.SAMPLES(SAMPLES)) u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .cmd       (lane_cmd),
      .sample    (req_tdata[2*SAMPLE_W-1:SAMPLE_W]),
      .dead_zone (dz_ff),
      .rsp       (y_rsp)
   );

   // merge: wait for both lanes and a free output, then register the result
   assign seen_now = seen_ff | {y_rsp.done, x_rsp.done};
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign load     = (state_ff == S_BUSY) && (&seen_now) && out_free;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cal_flag_in  = cal_flag_ff;
      cal_done_in  = cal_done_ff;
      seen_in      = seen_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               state_in    = S_BUSY;
               seen_in     = '0;
               cal_done_in = finish;
               if (req_tuser) begin
                  count_in    = finish ? '0 : count_next;
                  cal_flag_in = cal_flag_ff || finish;
               end
            end
         end
         S_BUSY: begin
            seen_in = seen_now;
            if (load) begin
               state_in     = S_IDLE;
               seen_in      = '0;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, cal_flag_ff, cal_done_ff,
                               y_rsp.direction, x_rsp.direction,
                               y_rsp.position, x_rsp.position};
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign dz_in      = (csr_write && csr_paddr == REG_DEAD_ZONE) ? csr_pwdata[DZ_W-1:0] : dz_ff;
   assign csr_prdata = (csr_paddr == REG_DEAD_ZONE) ? CSR_DATA_W'(dz_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cal_flag_ff  <= 1'b0;
         cal_done_ff  <= 1'b0;
         seen_ff      <= '0;
         dz_ff        <= DEAD_ZONE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cal_flag_ff  <= cal_flag_in;
         cal_done_ff  <= cal_done_in;
         seen_ff      <= seen_in;
         dz_ff        <= dz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(SAMPLES))
      else $error("calibration count out of range");

   a_done_implies_cal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[CAL_DONE_BIT] |-> rsp_data_ff[IS_CAL_BIT])
      else $error("calibration done without calibrated flag");

   a_accept_to_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == S_BUSY)
      else $error("transaction accepted but no work started");

endmodule
